/* rtl/bst_pkg.sv */
// Package for the byte stream tokenizer: scan modes, token kinds, error codes
// and the result record shared by the step logic and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int NUM_W = 31;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  typedef enum logic [9:0] {
    M_IDLE    = 10'b00_0000_0001,
    M_NUM     = 10'b00_0000_0010,
    M_IDENT   = 10'b00_0000_0100,
    M_STR     = 10'b00_0000_1000,
    M_P_MINUS = 10'b00_0001_0000,
    M_P_EQ    = 10'b00_0010_0000,
    M_P_LT    = 10'b00_0100_0000,
    M_P_GT    = 10'b00_1000_0000,
    M_P_BANG  = 10'b01_0000_0000,
    M_HALT    = 10'b10_0000_0000
  } mode_t;

  typedef enum logic [4:0] {
    K_TEXT    = 5'd0,
    K_STREND  = 5'd1,
    K_NUM     = 5'd2,
    K_PLUS    = 5'd3,
    K_MINUS   = 5'd4,
    K_STAR    = 5'd5,
    K_SLASH   = 5'd6,
    K_PERCENT = 5'd7,
    K_EQUAL   = 5'd8,
    K_LESS    = 5'd9,
    K_MORE    = 5'd10,
    K_BANG    = 5'd11,
    K_COMMA   = 5'd12,
    K_PIPE    = 5'd13,
    K_DOLLAR  = 5'd14,
    K_ARROW   = 5'd15,
    K_DBMORE  = 5'd16,
    K_DBEQUAL = 5'd17,
    K_BANGEQ  = 5'd18,
    K_LESSEQ  = 5'd19,
    K_MOREEQ  = 5'd20,
    K_LPAREN  = 5'd21,
    K_RPAREN  = 5'd22,
    K_LBRACE  = 5'd23,
    K_RBRACE  = 5'd24,
    K_SEMI    = 5'd25,
    K_EOF     = 5'd26,
    K_ERROR   = 5'd27
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_UNTERM  = 2'd2
  } err_t;

  typedef struct packed {
    kind_t            kind;
    logic [NUM_W-1:0] num;
    logic [7:0]       txt;
    err_t             err;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0]       n;
    result_t          r0;
    result_t          r1;
    mode_t            mode;
    logic [NUM_W-1:0] acc;
  } step_t;

endpackage

`default_nettype wire

/* rtl/bst_step.sv */
// Combinational step of the tokenizer: one source byte and the current scan
// state give the next state and up to two results.
// Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_step (
  input  var bst_pkg::mode_t             mode,
  input  var logic [bst_pkg::NUM_W-1:0]  acc,
  input  var logic [7:0]                 c,
  output bst_pkg::step_t                 step
);
  import bst_pkg::*;

  typedef struct packed {
    logic             emit;
    result_t          res;
    mode_t            mode;
    logic [NUM_W-1:0] acc;
  } idle_t;

  function automatic result_t mk(kind_t k, logic [7:0] t, err_t e);
    result_t r;
    r.kind = k;
    r.num  = '0;
    r.txt  = t;
    r.err  = e;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic idle_t idle_fn(logic [7:0] b);
    idle_t o;
    logic [7:0] d;
    d      = b - 8'h30;
    o.emit = 1'b1;
    o.res  = mk(K_EOF, 8'h00, ERR_NONE);
    o.mode = M_IDLE;
    o.acc  = '0;
    if ((b == " ") || ((b >= 8'd9) && (b <= 8'd13))) begin
      o.emit = 1'b0;
    end else if (is_digit(b)) begin
      o.emit = 1'b0;
      o.mode = M_NUM;
      o.acc  = NUM_W'(d[3:0]);
    end else if (is_alpha(b)) begin
      o.mode = M_IDENT;
      o.res  = mk(K_TEXT, b, ERR_NONE);
    end else begin
      case (b)
        "\"": begin o.emit = 1'b0; o.mode = M_STR; end
        "-": begin o.emit = 1'b0; o.mode = M_P_MINUS; end
        "=": begin o.emit = 1'b0; o.mode = M_P_EQ; end
        "<": begin o.emit = 1'b0; o.mode = M_P_LT; end
        ">": begin o.emit = 1'b0; o.mode = M_P_GT; end
        "!": begin o.emit = 1'b0; o.mode = M_P_BANG; end
        "+": o.res = mk(K_PLUS, 8'h00, ERR_NONE);
        "*": o.res = mk(K_STAR, 8'h00, ERR_NONE);
        "/": o.res = mk(K_SLASH, 8'h00, ERR_NONE);
        "%": o.res = mk(K_PERCENT, 8'h00, ERR_NONE);
        ",": o.res = mk(K_COMMA, 8'h00, ERR_NONE);
        "|": o.res = mk(K_PIPE, 8'h00, ERR_NONE);
        "$": o.res = mk(K_DOLLAR, 8'h00, ERR_NONE);
        "(": o.res = mk(K_LPAREN, 8'h00, ERR_NONE);
        ")": o.res = mk(K_RPAREN, 8'h00, ERR_NONE);
        "{": o.res = mk(K_LBRACE, 8'h00, ERR_NONE);
        "}": o.res = mk(K_RBRACE, 8'h00, ERR_NONE);
        ";": o.res = mk(K_SEMI, 8'h00, ERR_NONE);
        8'h00: o.res = mk(K_EOF, 8'h00, ERR_NONE);
        default: begin
          o.mode = M_HALT;
          o.res  = mk(K_ERROR, 8'h00, ERR_UNKNOWN);
        end
      endcase
    end
    return o;
  endfunction

  idle_t            id;
  logic [7:0]       dig;
  logic [NUM_W+3:0] prod;
  logic             pend;
  kind_t            single;
  kind_t            pair;
  logic             has_pair;
  result_t          num_res;

  assign id  = idle_fn(c);
  assign dig = c - 8'h30;
  assign prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUM_W + 4)'(dig[3:0]);

  always_comb begin
    num_res     = mk(K_NUM, 8'h00, ERR_NONE);
    num_res.num = acc;
  end

  always_comb begin
    pend     = 1'b0;
    single   = K_MINUS;
    pair     = K_ARROW;
    has_pair = 1'b0;
    step.n    = 2'd0;
    step.r0   = mk(K_TEXT, 8'h00, ERR_NONE);
    step.r1   = mk(K_TEXT, 8'h00, ERR_NONE);
    step.mode = mode;
    step.acc  = acc;
    unique case (mode)
      M_HALT: begin
      end
      M_NUM: begin
        if (is_digit(c)) begin
          step.acc = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[NUM_W-1:0];
        end else begin
          step.r0   = num_res;
          step.r1   = id.res;
          step.mode = id.mode;
          step.acc  = id.acc;
          step.n    = id.emit ? 2'd2 : 2'd1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          step.r0 = mk(K_TEXT, c, ERR_NONE);
          step.n  = 2'd1;
        end else begin
          step.r0   = mk(K_STREND, 8'h00, ERR_NONE);
          step.r1   = id.res;
          step.mode = id.mode;
          step.acc  = id.acc;
          step.n    = id.emit ? 2'd2 : 2'd1;
        end
      end
      M_STR: begin
        step.n = 2'd1;
        if (c == "\"") begin
          step.r0   = mk(K_STREND, 8'h00, ERR_NONE);
          step.mode = M_IDLE;
        end else if (c == 8'h00) begin
          step.r0   = mk(K_ERROR, 8'h00, ERR_UNTERM);
          step.mode = M_HALT;
        end else begin
          step.r0 = mk(K_TEXT, c, ERR_NONE);
        end
      end
      M_P_MINUS: begin
        pend = 1'b1; single = K_MINUS;
        pair = K_ARROW; has_pair = (c == ">");
      end
      M_P_EQ: begin
        pend = 1'b1; single = K_EQUAL;
        pair = K_DBEQUAL; has_pair = (c == "=");
      end
      M_P_LT: begin
        pend = 1'b1; single = K_LESS;
        pair = K_LESSEQ; has_pair = (c == "=");
      end
      M_P_GT: begin
        pend = 1'b1; single = K_MORE;
        pair = (c == ">") ? K_DBMORE : K_MOREEQ;
        has_pair = (c == "=") || (c == ">");
      end
      M_P_BANG: begin
        pend = 1'b1; single = K_BANG;
        pair = K_BANGEQ; has_pair = (c == "=");
      end
      default: begin
        step.r0   = id.res;
        step.mode = id.mode;
        step.acc  = id.acc;
        step.n    = id.emit ? 2'd1 : 2'd0;
      end
    endcase
    if (pend) begin
      if (has_pair) begin
        step.r0   = mk(pair, 8'h00, ERR_NONE);
        step.mode = M_IDLE;
        step.n    = 2'd1;
      end else begin
        step.r0   = mk(single, 8'h00, ERR_NONE);
        step.r1   = id.res;
        step.mode = id.mode;
        step.acc  = id.acc;
        step.n    = id.emit ? 2'd2 : 2'd1;
      end
    end
    if (step.n == 2'd1) begin
      step.r0.last = 1'b1;
    end
    if (step.n == 2'd2) begin
      step.r1.last = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/byte_stream_tokenizer_core.sv */
// Top level of the byte stream tokenizer: input register, scan state,
// four-entry result queue and the two valid/stall channels.
// Depends on bst_pkg and bst_step.
`timescale 1ns / 1ps
`default_nettype none

// The tokenizer takes one source byte per cycle and gives zero, one or two
// result transactions for it, one result per cycle on the output side. A
// byte waits in the input register, where it updates the scan state
// and writes its results into a four-entry queue, from which the output
// reads them in order. A byte moves on only while the queue, after this
// cycle's read, holds at most two entries, so the input runs at one byte
// per cycle as long as the output is not stalled and bytes give at most
// one result each; a run of bytes that each give two results is held to
// the output rate of one result per cycle. After an unknown byte or an
// unterminated string the block reports an error and drops all further
// input until reset.
module byte_stream_tokenizer_core (
  input  var logic                      clk,
  input  var logic                      rst,
  input  var logic                      src_valid,
  output logic                          src_stall,
  input  var logic [7:0]                source_byte,
  output logic                          tok_valid,
  input  var logic                      tok_stall,
  output logic [4:0]                    token_kind,
  output logic [bst_pkg::NUM_W-1:0]     number_value,
  output logic [7:0]                    text_byte,
  output logic [1:0]                    error_code,
  output logic                          last
);
  import bst_pkg::*;

  logic             in_full;
  logic [7:0]       in_byte;
  mode_t            mode;
  logic [NUM_W-1:0] acc;
  step_t            step;
  result_t          queue [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       count;
  logic [2:0]       count_next;
  logic [2:0]       after_pop;
  logic             pop;
  logic             fire;
  logic             accept;
  logic [1:0]       push_n;
  result_t          head;

  bst_step u_step (
    .mode (mode),
    .acc  (acc),
    .c    (in_byte),
    .step (step)
  );

  assign pop        = tok_valid && !tok_stall;
  assign after_pop  = count - {2'b0, pop};
  assign fire       = in_full && (after_pop <= 3'd2);
  assign src_stall  = in_full && !fire;
  assign accept     = src_valid && !src_stall;
  assign push_n     = fire ? step.n : 2'd0;
  assign count_next = after_pop + {1'b0, push_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mode    <= M_IDLE;
      acc     <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        mode <= step.mode;
        acc  <= step.acc;
      end
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= source_byte;
    end
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= step.r0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= step.r1;
    end
  end

  assign head         = queue[rd_ptr];
  assign tok_valid    = (count != 3'd0);
  assign token_kind   = head.kind;
  assign number_value = head.num;
  assign text_byte    = head.txt;
  assign error_code   = head.err;
  assign last         = head.last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue holds more than four entries");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fire |-> count_next <= 3'd4)
    else $error("result queue written beyond its depth");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (fire && step.n == 2'd2) |-> (!step.r0.last && step.r1.last))
    else $error("only the second result of a byte may carry last");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == M_HALT |=> mode == M_HALT)
    else $error("halted scanner left the halted mode without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == M_HALT) |-> step.n == 2'd0)
    else $error("halted scanner produced a result");
`endif

endmodule

`default_nettype wire
